[sv/state_vector_measurement_engine_top_macros.svh]
// ---------------------------------------------------------------------------
// svme assertion macros
// concurrent assertion helpers shared by the measurement engine rtl
// ---------------------------------------------------------------------------
`ifndef STATE_VECTOR_MEASUREMENT_ENGINE_TOP_MACROS_SVH
`define STATE_VECTOR_MEASUREMENT_ENGINE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SVME_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svme assertion failed");

// next-cycle implication, off during reset
`define SVME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svme assertion failed");

`endif

[sv/svme_pkg.sv]
// ---------------------------------------------------------------------------
// svme_pkg
// types, constants and helpers of the state vector measurement engine
// ---------------------------------------------------------------------------
package svme_pkg;

    // index widths of the channels are sized for this qubit count
    localparam int MAX_QUBITS = 10;

    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_MEAS_QB  = 3'd2,
        CMD_MEAS_ALL = 3'd3,
        CMD_SAMPLE   = 3'd4
    } t_cmd;

    localparam logic [2:0]  REG_QUBITS   = 3'd0;
    localparam logic [3:0]  QUBITS_RESET = 4'd10;
    localparam logic [16:0] PROB_ONE     = 17'd65536;
    localparam logic [15:0] AMP_MAX      = 16'h7FFF;
    localparam logic [15:0] AMP_MIN      = 16'h8000;
    localparam logic [5:0]  DIV_STEPS    = 6'd35;
    localparam logic [5:0]  SQRT_STEPS   = 6'd17;

    // q2.30 to q1.16 with rounding, saturated at one
    function automatic logic [16:0] q30_to_q16(input logic [47:0] p);
        logic [48:0] s;
        logic [34:0] v;
        s = {1'b0, p} + 49'd8192;
        v = s[48:14];
        q30_to_q16 = (v > 35'(PROB_ONE)) ? PROB_ONE : v[16:0];
    endfunction

endpackage

[sv/svme_if.sv]
// ---------------------------------------------------------------------------
// svme channel interfaces
// valid/ready channels for commands and results
// ---------------------------------------------------------------------------
interface svme_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [9:0]  amp_index;
    logic signed [15:0] write_real;
    logic signed [15:0] write_imag;
    logic [3:0]  qubit_select;
    logic [15:0] random_value;

    modport source (output valid, command, amp_index, write_real, write_imag,
                    qubit_select, random_value, input ready);
    modport sink   (input valid, command, amp_index, write_real, write_imag,
                    qubit_select, random_value, output ready);
endinterface

interface svme_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  outcome;
    logic [16:0] probability;
    logic signed [15:0] read_real;
    logic signed [15:0] read_imag;
    logic        index_error;

    modport source (output valid, outcome, probability, read_real, read_imag,
                    index_error, input ready);
    modport sink   (input valid, outcome, probability, read_real, read_imag,
                    index_error, output ready);
endinterface

[sv/state_vector_measurement_engine_top.sv]
// ---------------------------------------------------------------------------
// state vector measurement engine
// amplitude store with write, read, single qubit measure, measure all, sample
// ---------------------------------------------------------------------------
//  channel | dir | handshake        | carries
//  i_cmd   | in  | valid/ready      | command, index, amplitude, qubit, random
//  o_res   | out | valid/ready      | outcome, probability, amplitude, error
//  apb     | in  | psel/penable     | qubits_in_use at byte address 0
//
//  write, bad command and bad index go straight to the finish state, read goes
//  through the read state; sample scans up to the picked amplitude, measure all then
//  clears the whole store; measure qubit runs a sum pass, then a collapse pass that zeroes
//  each dropped amplitude and rescales each kept one, if the kept sum is not zero, with the
//  shared bit-serial divider and square root (one bit per cycle, real then imaginary part)
//  one item at a time; a result waits in the output register while the next
//  command is taken; synchronous active-low reset, amplitude store not cleared
// ---------------------------------------------------------------------------
`include "state_vector_measurement_engine_top_macros.svh"

module state_vector_measurement_engine_top
    import svme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    svme_in_if.sink     i_cmd,
    svme_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_QUBITS + 1);
    localparam int CW    = AW + 1;
    localparam int SW    = AW + 32;
    localparam int DW    = SW + 35;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD     = 13'b0000000000010,
        ST_SCAN   = 13'b0000000000100,
        ST_DECIDE = 13'b0000000001000,
        ST_CRD    = 13'b0000000010000,
        ST_CCHK   = 13'b0000000100000,
        ST_SQ     = 13'b0000001000000,
        ST_DIV    = 13'b0000010000000,
        ST_SQRT   = 13'b0000100000000,
        ST_RND    = 13'b0001000000000,
        ST_CWR    = 13'b0010000000000,
        ST_CLEAR  = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0] r_qubits;
    logic       cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUBITS) ? {28'd0, r_qubits} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubits <= QUBITS_RESET;
        end else if (cfg_wr && paddr == REG_QUBITS) begin
            r_qubits <= pwdata[3:0];
        end
    end

    logic [NW-1:0] n_eff;
    logic [CW-1:0] dim, dim_m1;
    always_comb begin
        if (r_qubits == 4'd0) begin
            n_eff = NW'(1);
        end else if (int'(r_qubits) > MAX_QUBITS) begin
            n_eff = NW'(MAX_QUBITS);
        end else begin
            n_eff = NW'(r_qubits);
        end
    end
    assign dim    = CW'(1) << n_eff;
    assign dim_m1 = dim - CW'(1);

    // amplitude store
    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rd <= mem[mem_addr];
    end

    // working registers
    t_cmd          r_cmd;
    logic [29:0]   r_r30;
    logic [NW-1:0] r_pos;
    logic [CW-1:0] r_i;
    logic [AW-1:0] r_walk;
    logic          r_v1, r_v2, r_v3;
    logic [AW-1:0] r_idx1, r_idx2, r_idx3;
    logic          r_b1, r_b2, r_b3;
    logic [30:0]   r_re2, r_im2;
    logic [31:0]   r_mag;
    logic [SW-1:0] r_s0, r_s1, r_cum, r_keep;
    logic          r_out_bit;
    logic [15:0]   r_m;
    logic          r_neg;
    logic          r_part;
    logic [15:0]   r_word_im;
    logic [15:0]   r_new_re, r_new_im;
    logic [DW-1:0] r_rem, r_div;
    logic [34:0]   r_y;
    logic          r_sat;
    logic [5:0]    r_cnt;
    logic [35:0]   r_x, r_res, r_bit;

    logic [9:0]    r_res_outcome;
    logic [16:0]   r_res_prob;
    logic [15:0]   r_res_re, r_res_im;
    logic          r_res_err;

    logic          r_out_valid;
    logic [9:0]    r_out_outcome;
    logic [16:0]   r_out_prob;
    logic [15:0]   r_out_re, r_out_im;
    logic          r_out_err;

    // input decode
    logic          in_xfer;
    t_cmd          in_cmd;
    logic          idx_err, qb_err;
    logic [NW-1:0] in_pos;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign in_cmd      = t_cmd'(i_cmd.command);
    assign idx_err     = 32'(i_cmd.amp_index) >= 32'(dim);
    assign qb_err      = 32'(i_cmd.qubit_select) >= 32'(n_eff);
    assign in_pos      = NW'(5'(n_eff) - 5'd1 - 5'(i_cmd.qubit_select));

    // scan pipeline helpers
    logic          issue;
    logic [CW-1:0] i_shift;
    logic [SW-1:0] cum_next;
    logic          last3, walk_hit;
    logic signed [31:0] sq_re, sq_im;
    assign issue    = (r_state == ST_SCAN) && (r_i < dim);
    assign i_shift  = r_i >> r_pos;
    assign sq_re    = 32'(signed'(r_rd[15:0])) * 32'(signed'(r_rd[15:0]));
    assign sq_im    = 32'(signed'(r_rd[31:16])) * 32'(signed'(r_rd[31:16]));
    assign cum_next = r_cum + SW'(r_mag);
    assign last3    = r_v3 && ({1'b0, r_idx3} == dim_m1);
    assign walk_hit = r_v3 && ((SW'(r_r30) < cum_next) || last3);

    // collapse helpers
    logic          c_bit, c_agree, c_last;
    logic [CW-1:0] c_shift;
    assign c_shift = r_i >> r_pos;
    assign c_bit   = c_shift[0];
    assign c_agree = (c_bit == r_out_bit);
    assign c_last  = (r_i == dim_m1);

    logic [16:0]   p16_s0;
    logic          dec_bit;
    assign p16_s0  = q30_to_q16(48'(r_s0));
    assign dec_bit = !(SW'(r_r30) < r_s0);

    logic [31:0]   m_sq;
    logic          div_ge;
    logic [35:0]   sq_t, q_round;
    logic [15:0]   part_val;
    logic [15:0]   abs_re, abs_im;
    assign m_sq    = 32'(r_m) * 32'(r_m);
    assign div_ge  = r_rem >= r_div;
    assign sq_t    = r_res + r_bit;
    assign q_round = (r_res + 36'd1) >> 1;
    assign abs_re  = r_rd[15] ? (16'd0 - r_rd[15:0]) : r_rd[15:0];
    assign abs_im  = r_word_im[15] ? (16'd0 - r_word_im) : r_word_im;

    always_comb begin
        if (r_neg) begin
            part_val = (r_sat || q_round > 36'd32768) ? AMP_MIN : 16'(36'd0 - q_round);
        end else begin
            part_val = (r_sat || q_round > 36'(AMP_MAX)) ? AMP_MAX : q_round[15:0];
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || o_res.ready;

    // memory port control
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_i[AW-1:0];
        mem_wd   = 32'd0;
        unique case (r_state)
            ST_IDLE: begin
                mem_addr = AW'(i_cmd.amp_index);
                mem_we   = in_xfer && in_cmd == CMD_WRITE && !idx_err;
                mem_wd   = {i_cmd.write_imag, i_cmd.write_real};
            end
            ST_CCHK: begin
                mem_we = !c_agree;
            end
            ST_CWR: begin
                mem_we = 1'b1;
                mem_wd = {r_new_im, r_new_re};
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = (r_i[AW-1:0] == r_walk) ? {16'd0, AMP_MAX} : 32'd0;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (in_cmd) inside
                        CMD_READ:                 n_state = idx_err ? ST_FIN : ST_RD;
                        CMD_MEAS_QB:              n_state = qb_err ? ST_FIN : ST_SCAN;
                        CMD_MEAS_ALL, CMD_SAMPLE: n_state = ST_SCAN;
                        default:                  n_state = ST_FIN;
                    endcase
                end
            end
            ST_RD:     n_state = ST_FIN;
            ST_SCAN: begin
                if (r_cmd == CMD_MEAS_QB) begin
                    if (last3) n_state = ST_DECIDE;
                end else if (walk_hit) begin
                    n_state = (r_cmd == CMD_MEAS_ALL) ? ST_CLEAR : ST_FIN;
                end
            end
            ST_DECIDE: n_state = ST_CRD;
            ST_CRD:    n_state = ST_CCHK;
            ST_CCHK: begin
                if (c_agree && r_keep != '0) begin
                    n_state = ST_SQ;
                end else begin
                    n_state = c_last ? ST_FIN : ST_CRD;
                end
            end
            ST_SQ:     n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'd0 && div_ge) begin
                    n_state = ST_RND;
                end else if (r_cnt == DIV_STEPS) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT:   if (r_cnt == SQRT_STEPS) n_state = ST_RND;
            ST_RND:    n_state = r_part ? ST_CWR : ST_SQ;
            ST_CWR:    n_state = c_last ? ST_FIN : ST_CRD;
            ST_CLEAR:  if (r_i == CW'(DEPTH - 1)) n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1 && (r_state == ST_SCAN);
            r_v3    <= r_v2 && (r_state == ST_SCAN);
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_i[AW-1:0];
        r_b1   <= i_shift[0];
        r_idx2 <= r_idx1;
        r_b2   <= r_b1;
        r_re2  <= sq_re[30:0];
        r_im2  <= sq_im[30:0];
        r_idx3 <= r_idx2;
        r_b3   <= r_b2;
        r_mag  <= 32'(r_re2) + 32'(r_im2);
        if (issue) begin
            r_i <= r_i + CW'(1);
        end

        if (r_state == ST_FIN && out_free) begin
            r_out_outcome <= r_res_outcome;
            r_out_prob    <= r_res_prob;
            r_out_re      <= r_res_re;
            r_out_im      <= r_res_im;
            r_out_err     <= r_res_err;
        end

        case (r_state)
            ST_IDLE: begin
                r_cmd         <= in_cmd;
                r_r30         <= {i_cmd.random_value, 14'd0};
                r_pos         <= in_pos;
                r_i           <= '0;
                r_s0          <= '0;
                r_s1          <= '0;
                r_cum         <= '0;
                r_res_outcome <= '0;
                r_res_prob    <= '0;
                r_res_re      <= '0;
                r_res_im      <= '0;
                r_res_err     <= ((in_cmd == CMD_WRITE || in_cmd == CMD_READ) && idx_err)
                                 || (in_cmd == CMD_MEAS_QB && qb_err);
            end
            ST_RD: begin
                r_res_re <= r_rd[15:0];
                r_res_im <= r_rd[31:16];
            end
            ST_SCAN: begin
                if (r_v3) begin
                    if (r_cmd == CMD_MEAS_QB) begin
                        if (r_b3) r_s1 <= r_s1 + SW'(r_mag);
                        else      r_s0 <= r_s0 + SW'(r_mag);
                    end else begin
                        r_cum <= cum_next;
                        if (walk_hit) begin
                            r_res_outcome <= 10'(r_idx3);
                            r_res_prob    <= q30_to_q16(48'(r_mag));
                            r_walk        <= r_idx3;
                            r_i           <= '0;
                        end
                    end
                end
            end
            ST_DECIDE: begin
                r_out_bit     <= dec_bit;
                r_keep        <= dec_bit ? r_s1 : r_s0;
                r_res_outcome <= 10'(dec_bit);
                r_res_prob    <= dec_bit ? (PROB_ONE - p16_s0) : p16_s0;
                r_i           <= '0;
            end
            ST_CCHK: begin
                r_m       <= abs_re;
                r_neg     <= r_rd[15];
                r_word_im <= r_rd[31:16];
                r_part    <= 1'b0;
                if (!(c_agree && r_keep != '0) && !c_last) begin
                    r_i <= r_i + CW'(1);
                end
            end
            ST_SQ: begin
                r_rem <= DW'({m_sq, 32'd0});
                r_div <= DW'(r_keep) << 35;
                r_y   <= '0;
                r_cnt <= '0;
                r_sat <= 1'b0;
            end
            ST_DIV: begin
                if (r_cnt == 6'd0) begin
                    r_sat <= div_ge;
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt + 6'd1;
                end else begin
                    if (div_ge) r_rem <= r_rem - r_div;
                    r_y   <= {r_y[33:0], div_ge};
                    r_div <= r_div >> 1;
                    if (r_cnt == DIV_STEPS) begin
                        r_x   <= 36'({r_y[33:0], div_ge});
                        r_res <= '0;
                        r_bit <= 36'd1 << 34;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
            end
            ST_SQRT: begin
                if (r_x >= sq_t) begin
                    r_x   <= r_x - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
            end
            ST_RND: begin
                if (!r_part) begin
                    r_new_re <= part_val;
                    r_part   <= 1'b1;
                    r_m      <= abs_im;
                    r_neg    <= r_word_im[15];
                end else begin
                    r_new_im <= part_val;
                end
            end
            ST_CWR: begin
                if (!c_last) r_i <= r_i + CW'(1);
            end
            ST_CLEAR: begin
                r_i <= r_i + CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.outcome     = r_out_outcome;
    assign o_res.probability = r_out_prob;
    assign o_res.read_real   = r_out_re;
    assign o_res.read_imag   = r_out_im;
    assign o_res.index_error = r_out_err;

    // every accepted command leaves idle
    `SVME_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_xfer, r_state != ST_IDLE)
    // the sum and walk passes never write the store
    `SVME_ASSERT_SAME(a_scan_read_only, i_clk, i_rst_n, r_state == ST_SCAN, !mem_we)
    // a new result is only loaded from the finish state
    `SVME_ASSERT_SAME(a_result_from_fin, i_clk, i_rst_n,
                      $rose(r_out_valid), $past(r_state == ST_FIN))
    // divider step counter stays in range
    `SVME_ASSERT_SAME(a_div_count, i_clk, i_rst_n, r_state == ST_DIV, r_cnt <= DIV_STEPS)

endmodule

[sim/state_vector_measurement_engine_top_tb.sv]
// ---------------------------------------------------------------------------
// state vector measurement engine testbench
// drives commands through the valid/ready input channel, predicts every
// result with an integer model of the amplitude store and checks each
// transfer on the result channel, across several qubit counts set over apb
// ---------------------------------------------------------------------------
module state_vector_measurement_engine_top_tb;
    import svme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STORE_WORDS = 1024;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic [9:0]         amp_index;
        logic signed [15:0] write_real;
        logic signed [15:0] write_imag;
        logic [3:0]         qubit_select;
        logic [15:0]        random_value;
    } t_command;

    typedef struct packed {
        logic [9:0]         outcome;
        logic [16:0]        probability;
        logic signed [15:0] read_real;
        logic signed [15:0] read_imag;
        logic               index_error;
    } t_measurement;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    svme_in_if  cmd_if ();
    svme_out_if res_if ();

    state_vector_measurement_engine_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_command     cmd_queue[$];
    t_measurement expected_results[$];
    logic [31:0]  amp_model[STORE_WORDS];
    logic [3:0]   qubit_reg;
    bit           stall_on;
    int           src_gap;
    int           sink_gap;
    int           mismatches;
    int           results_seen;
    int           cmd_count[8];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------- model

    function automatic int eff_qubits();
        if (qubit_reg < 1) return 1;
        if (qubit_reg > 10) return 10;
        return int'(qubit_reg);
    endfunction

    function automatic longint unsigned energy(logic [31:0] w);
        longint re;
        longint im;
        re = longint'($signed(w[15:0]));
        im = longint'($signed(w[31:16]));
        return longint'(re * re + im * im);
    endfunction

    function automatic logic [16:0] to_q16(longint unsigned p);
        longint unsigned v;
        v = (p + 64'd8192) >> 14;
        return (v > 64'd65536) ? 17'd65536 : v[16:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // round(a * 2^15 / sqrt(s)), ties away from zero, saturated
    function automatic logic [15:0] rescale(logic signed [15:0] a, longint unsigned s);
        longint          av;
        longint unsigned mag;
        longint unsigned q;
        av = longint'(a);
        mag = (av < 0) ? -av : av;
        q = (int_sqrt(((mag * mag) << 32) / s) + 1) >> 1;
        if (av < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-longint'(q));
        end
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function automatic t_measurement predict_measurement(t_command c);
        t_measurement    m;
        int              n;
        int              dim;
        int              pos;
        longint unsigned r30;
        longint unsigned s0;
        longint unsigned s1;
        longint unsigned kept;
        longint unsigned cum;
        logic [16:0]     p16;
        logic [31:0]     w;
        int              pick;
        m = '0;
        n = eff_qubits();
        dim = 1 << n;
        r30 = longint'(c.random_value) << 14;
        case (c.command)
            CMD_WRITE, CMD_READ: begin
                if (c.amp_index >= dim) begin
                    m.index_error = 1'b1;
                end else if (c.command == CMD_WRITE) begin
                    amp_model[c.amp_index] = {c.write_imag, c.write_real};
                end else begin
                    m.read_real = amp_model[c.amp_index][15:0];
                    m.read_imag = amp_model[c.amp_index][31:16];
                end
            end
            CMD_MEAS_QB: begin
                if (c.qubit_select >= n) begin
                    m.index_error = 1'b1;
                end else begin
                    pos = n - 1 - c.qubit_select;
                    s0 = 0;
                    s1 = 0;
                    for (int i = 0; i < dim; i++) begin
                        if ((i >> pos) & 1) s1 += energy(amp_model[i]);
                        else s0 += energy(amp_model[i]);
                    end
                    m.outcome = (r30 < s0) ? 10'd0 : 10'd1;
                    p16 = to_q16(s0);
                    m.probability = m.outcome[0] ? PROB_ONE - p16 : p16;
                    kept = m.outcome[0] ? s1 : s0;
                    for (int i = 0; i < dim; i++) begin
                        w = amp_model[i];
                        if (((i >> pos) & 1) != m.outcome[0]) begin
                            amp_model[i] = '0;
                        end else if (kept != 0) begin
                            amp_model[i] = {rescale(w[31:16], kept), rescale(w[15:0], kept)};
                        end
                    end
                end
            end
            CMD_MEAS_ALL, CMD_SAMPLE: begin
                cum = 0;
                pick = dim - 1;
                for (int i = 0; i < dim; i++) begin
                    cum += energy(amp_model[i]);
                    if (r30 < cum) begin
                        pick = i;
                        break;
                    end
                end
                m.outcome = pick[9:0];
                m.probability = to_q16(energy(amp_model[pick]));
                if (c.command == CMD_MEAS_ALL) begin
                    foreach (amp_model[i]) amp_model[i] = '0;
                    amp_model[pick] = {16'd0, AMP_MAX};
                end
            end
            default: ;
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------- stimulus

    task automatic issue(logic [2:0] cmd, int idx, int re, int im, int qs, int rv);
        t_command c;
        c.command      = cmd;
        c.amp_index    = idx[9:0];
        c.write_real   = re[15:0];
        c.write_imag   = im[15:0];
        c.qubit_select = qs[3:0];
        c.random_value = rv[15:0];
        cmd_count[cmd]++;
        expected_results.push_back(predict_measurement(c));
        cmd_queue.push_back(c);
    endtask

    function automatic int random_amp();
        int lim;
        case ($urandom_range(0, 7))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return 0;
            default: begin
                lim = 23170 >> (eff_qubits() / 2);
                return int'($urandom_range(0, 2 * lim)) - lim;
            end
        endcase
    endfunction

    task automatic load_vector();
        for (int i = 0; i < (1 << eff_qubits()); i++)
            issue(CMD_WRITE, i, random_amp(), random_amp(), 0, $urandom_range(0, 65535));
    endtask

    task automatic random_traffic(int count, bit qubit_ok);
        int n;
        int dim;
        int sel;
        int idx;
        n = eff_qubits();
        dim = 1 << n;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            idx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, dim - 1);
            if (sel < 35)
                issue(CMD_WRITE, idx, random_amp(), random_amp(), $urandom_range(0, 15),
                      $urandom_range(0, 65535));
            else if (sel < 55)
                issue(CMD_READ, idx, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 15), $urandom_range(0, 65535));
            else if (sel < 70 && qubit_ok)
                issue(CMD_MEAS_QB, $urandom_range(0, 1023), 0, 0,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, n - 1),
                      $urandom_range(0, 65535));
            else if (sel < 82)
                issue(CMD_MEAS_ALL, $urandom_range(0, 1023), 0, 0, 0, $urandom_range(0, 65535));
            else if (sel < 97)
                issue(CMD_SAMPLE, $urandom_range(0, 1023), 0, 0, 0, $urandom_range(0, 65535));
            else
                issue(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), idx, 0, 0, 0,
                      $urandom_range(0, 65535));
        end
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_qubits(logic [3:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_QUBITS;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        qubit_reg = value;
        @(posedge i_clk);
    endtask

    // ----------------------------------------------------------- driver side

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) void'(cmd_queue.pop_front());
            // payload may only change once the current transfer is done
            if (!cmd_if.valid || cmd_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (stall_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 11) - 1;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    cmd_if.valid        <= 1'b1;
                    cmd_if.command      <= cmd_queue[0].command;
                    cmd_if.amp_index    <= cmd_queue[0].amp_index;
                    cmd_if.write_real   <= cmd_queue[0].write_real;
                    cmd_if.write_imag   <= cmd_queue[0].write_imag;
                    cmd_if.qubit_select <= cmd_queue[0].qubit_select;
                    cmd_if.random_value <= cmd_queue[0].random_value;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------- monitor side

    always @(posedge i_clk) begin
        t_measurement want;
        t_measurement got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = {res_if.outcome, res_if.probability, res_if.read_real,
                       res_if.read_imag, res_if.index_error};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.outcome !== want.outcome || got.probability !== want.probability ||
                        got.read_real !== want.read_real || got.read_imag !== want.read_imag ||
                        got.index_error !== want.index_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch: expected %p, actual %p",
                                     results_seen, want, got);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                res_if.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(1, 11) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------- sequence

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.command = '0;
        cmd_if.amp_index = '0;
        cmd_if.write_real = '0;
        cmd_if.write_imag = '0;
        cmd_if.qubit_select = '0;
        cmd_if.random_value = '0;
        res_if.ready = 1'b0;
        stall_on = 1'b1;
        mismatches = 0;
        results_seen = 0;
        qubit_reg = QUBITS_RESET;
        foreach (amp_model[i]) amp_model[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of ten qubits: only entries written here are touched
        issue(CMD_WRITE, 1023, -12345, 23456, 0, 0);
        issue(CMD_READ, 1023, 0, 0, 0, 0);
        issue(CMD_WRITE, 0, 777, -888, 0, 0);
        issue(CMD_READ, 0, 0, 0, 0, 0);
        issue(CMD_MEAS_QB, 0, 0, 0, 12, $urandom_range(0, 65535));

        // two qubits: directed corner cases
        set_qubits(4'd2);
        load_vector();
        issue(CMD_WRITE, 0, 32767, -32768, 0, 0);
        issue(CMD_READ, 0, 0, 0, 0, 0);
        issue(CMD_WRITE, 3, -32768, 32767, 0, 0);
        issue(CMD_READ, 3, 0, 0, 0, 0);
        issue(CMD_WRITE, 4, 1, 1, 0, 0);
        issue(CMD_WRITE, 1023, -1, -1, 0, 0);
        issue(CMD_READ, 1023, 0, 0, 0, 0);
        issue(CMD_MEAS_QB, 0, 0, 0, 2, 0);
        issue(CMD_MEAS_QB, 0, 0, 0, 15, 65535);
        for (int u = CMD_UNUSED_LO; u <= CMD_UNUSED_HI; u++)
            issue(3'(u), 1, 5, 5, 1, 1);
        issue(CMD_WRITE, 0, 23170, 0, 0, 0);
        issue(CMD_WRITE, 1, 0, 0, 0, 0);
        issue(CMD_WRITE, 2, 0, 23170, 0, 0);
        issue(CMD_WRITE, 3, 0, 0, 0, 0);
        issue(CMD_SAMPLE, 0, 0, 0, 0, 0);
        issue(CMD_SAMPLE, 0, 0, 0, 0, 65535);
        issue(CMD_MEAS_QB, 0, 0, 0, 0, 0);
        // kept half is now empty, so no rescale
        issue(CMD_MEAS_QB, 0, 0, 0, 0, 65535);
        issue(CMD_READ, 0, 0, 0, 0, 0);
        // the collapse clears the whole store, so every entry is defined from here
        issue(CMD_MEAS_ALL, 0, 0, 0, 0, 0);
        issue(CMD_READ, 0, 0, 0, 0, 0);
        random_traffic(45, 1'b1);

        set_qubits(4'd1);
        load_vector();
        random_traffic(50, 1'b1);

        // zero acts as one qubit
        set_qubits(4'd0);
        load_vector();
        random_traffic(30, 1'b1);

        set_qubits(4'd3);
        load_vector();
        random_traffic(45, 1'b1);

        // fifteen clamps to ten, sparse vector over the full store
        set_qubits(4'd15);
        issue(CMD_WRITE, 0, 16384, 0, 0, 0);
        issue(CMD_WRITE, 600, 0, -16384, 0, 0);
        issue(CMD_WRITE, 1023, 11585, 11585, 0, 0);
        issue(CMD_WRITE, 300, -8192, 4096, 0, 0);
        issue(CMD_MEAS_QB, 0, 0, 0, 10, 0);
        issue(CMD_MEAS_QB, 0, 0, 0, 0, $urandom_range(0, 65535));
        random_traffic(8, 1'b0);

        // hold the sender until every result is back, then run without idling
        set_qubits(4'd4);
        stall_on = 1'b0;
        load_vector();
        random_traffic(45, 1'b1);

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d results over qubit counts 0, 1, 2, 3, 4, 10 and 15", results_seen);
        $display("writes %0d, reads %0d, qubit measures %0d, measure all %0d, samples %0d",
                 cmd_count[CMD_WRITE], cmd_count[CMD_READ], cmd_count[CMD_MEAS_QB],
                 cmd_count[CMD_MEAS_ALL], cmd_count[CMD_SAMPLE]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("state_vector_measurement_engine_top regression: pass");
        end else begin
            $display("state_vector_measurement_engine_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("state_vector_measurement_engine_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/svme_pkg.sv
sv/svme_if.sv
sv/state_vector_measurement_engine_top.sv
sim/state_vector_measurement_engine_top_tb.sv
